// ===== hdl/lobt_pkg.sv =====
// Package: status codes, operation codes, controller states, and slot, command and status structs.
package lobt_pkg;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_MODIFY = 2'd1,
    OP_DELETE = 2'd2,
    OP_LOOKUP = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_DUP       = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN1,
    S_APPLY,
    S_SCAN2,
    S_DONE
  } state_e;

  // one table entry as stored in the slot memory
  typedef struct packed {
    logic [31:0] id;
    logic [31:0] price;
    logic [30:0] qty;
    logic        side;
  } slot_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture request
    logic scan1_clr;  // reset scan pointer, clear match and free flags
    logic scan1_en;   // step identifier / free-slot scan
    logic apply;      // write table
    logic scan2_clr;  // reset best-price scan
    logic scan2_en;   // step best-price scan
    logic reply;      // drive result strobe
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan1_last;
    logic scan2_last;
  } stat_t;

endpackage

// ===== hdl/limit_order_book_table_top.sv =====
// Top level: limit order book table, controller plus datapath.
//
// Command channel: raise start_i with op_i, order_id_i, price_ticks_i, quantity_i and
// is_buy_i; the word is taken at a rising edge where start_i is high and busy_o is low.
// busy_o stays high until the reply strobe cycle, in which it is already low again.
// Reply channel: done_o is high for exactly one cycle with the reply word on the result
// ports (status, looked-up order, best bid and ask, active count). The receiver cannot
// stall; take the word in that cycle.
// Sequence: the next word can be taken at the edge that ends the strobe cycle. A request
// makes two passes over the slot memory, one slot per cycle through a registered read:
// the first finds the identifier and the lowest free slot, the second, after the table
// update, finds the best bid and ask.
// Reset: all slots empty, count zero, controller idle; no clearing pass is needed since
// per-slot valid bits clear at once.
module limit_order_book_table_top #(
  parameter int ORDER_SLOTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  op_i,
  input  logic [31:0] order_id_i,
  input  logic [31:0] price_ticks_i,
  input  logic signed [31:0] quantity_i,
  input  logic        is_buy_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [31:0] found_price_o,
  output logic [30:0] found_quantity_o,
  output logic        found_is_buy_o,
  output logic        bid_valid_o,
  output logic [31:0] best_bid_o,
  output logic        ask_valid_o,
  output logic [31:0] best_ask_o,
  output logic [6:0]  active_count_o
);

  lobt_pkg::cmd_t  cmd;
  lobt_pkg::stat_t stat;

  // sequence the request
  lobt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  // hold the table and do the scans
  lobt_dp #(.ORDER_SLOTS(ORDER_SLOTS)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .op_i            (op_i),
    .order_id_i      (order_id_i),
    .price_ticks_i   (price_ticks_i),
    .quantity_i      (quantity_i),
    .is_buy_i        (is_buy_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .found_price_o   (found_price_o),
    .found_quantity_o(found_quantity_o),
    .found_is_buy_o  (found_is_buy_o),
    .bid_valid_o     (bid_valid_o),
    .best_bid_o      (best_bid_o),
    .ask_valid_o     (ask_valid_o),
    .best_ask_o      (best_ask_o),
    .active_count_o  (active_count_o)
  );

endmodule

// ===== hdl/lobt_ctrl.sv =====
// Controller state machine: sequences capture, lookup scan, table update, best-price scan, reply.
module lobt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  lobt_pkg::stat_t    stat_i,
  output lobt_pkg::cmd_t     cmd_o,
  output logic               busy_o
);

  lobt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= lobt_pkg::S_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      lobt_pkg::S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load      = 1'b1;
          cmd_o.scan1_clr = 1'b1;
          state_d         = lobt_pkg::S_SCAN1;
        end
      end
      lobt_pkg::S_SCAN1: begin
        cmd_o.scan1_en = 1'b1;
        if (stat_i.scan1_last) state_d = lobt_pkg::S_APPLY;
      end
      lobt_pkg::S_APPLY: begin
        cmd_o.apply     = 1'b1;
        cmd_o.scan2_clr = 1'b1;
        state_d         = lobt_pkg::S_SCAN2;
      end
      lobt_pkg::S_SCAN2: begin
        cmd_o.scan2_en = 1'b1;
        if (stat_i.scan2_last) state_d = lobt_pkg::S_DONE;
      end
      lobt_pkg::S_DONE: begin
        cmd_o.reply = 1'b1;
        state_d     = lobt_pkg::S_IDLE;
      end
      default: state_d = lobt_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== hdl/lobt_dp.sv =====
// Datapath: order table with registered-read slot memory, slot scans, update and reply.
module lobt_dp #(
  parameter int ORDER_SLOTS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lobt_pkg::cmd_t    cmd_i,
  output lobt_pkg::stat_t   stat_o,
  input  logic [1:0]        op_i,
  input  logic [31:0]       order_id_i,
  input  logic [31:0]       price_ticks_i,
  input  logic signed [31:0] quantity_i,
  input  logic              is_buy_i,
  output logic              done_o,
  output logic [2:0]        status_o,
  output logic [31:0]       found_price_o,
  output logic [30:0]       found_quantity_o,
  output logic              found_is_buy_o,
  output logic              bid_valid_o,
  output logic [31:0]       best_bid_o,
  output logic              ask_valid_o,
  output logic [31:0]       best_ask_o,
  output logic [6:0]        active_count_o
);

  localparam int IW = $clog2(ORDER_SLOTS);
  localparam int CW = $clog2(ORDER_SLOTS + 1);

  // table: valid bits in reset flops, payload in a memory without reset
  logic [ORDER_SLOTS-1:0] valid_q;
  lobt_pkg::slot_t        mem_q [ORDER_SLOTS];
  logic [CW-1:0]          count_q;

  // captured request
  logic [1:0]  op_q;
  logic [31:0] rid_q, rprice_q;
  logic [31:0] rqty_q;
  logic        rbuy_q;

  // scan state: address stage and registered read stage
  logic [IW-1:0]   ptr_q;
  logic            issued_q;
  logic            pv_q;
  logic [IW-1:0]   idx_q;
  logic            slotv_q;
  lobt_pkg::slot_t rd_q;

  logic          hit_q, free_q;
  logic [IW-1:0] hit_idx_q, free_idx_q;
  logic [31:0]   hit_price_q;
  logic [30:0]   hit_qty_q;
  logic          hit_side_q;
  logic          have_bid_q, have_ask_q;
  logic [31:0]   bid_q, ask_q;
  logic [2:0]    status_q;
  logic [31:0]   fprice_q;
  logic [30:0]   fqty_q;
  logic          fbuy_q;
  logic          done_q;

  logic addr_last;
  logic issue;
  logic last;
  assign addr_last = (ptr_q == IW'(ORDER_SLOTS - 1));
  assign issue     = (cmd_i.scan1_en || cmd_i.scan2_en) && !issued_q;
  assign last      = pv_q && (idx_q == IW'(ORDER_SLOTS - 1));
  assign stat_o.scan1_last = last;
  assign stat_o.scan2_last = last;

  logic params_ok;
  assign params_ok = (rid_q != '0) && (rprice_q != '0) && (rqty_q != '0) && !rqty_q[31];

  logic            we;
  logic [IW-1:0]   waddr;
  lobt_pkg::slot_t wdata;
  assign we = cmd_i.apply &&
              ((op_q == lobt_pkg::OP_ADD && params_ok && !hit_q && free_q) ||
               (op_q == lobt_pkg::OP_MODIFY && params_ok && hit_q));
  assign waddr       = (op_q == lobt_pkg::OP_ADD) ? free_idx_q : hit_idx_q;
  assign wdata.id    = rid_q;
  assign wdata.price = rprice_q;
  assign wdata.qty   = rqty_q[30:0];
  // modify keeps the side found by the first scan
  assign wdata.side  = (op_q == lobt_pkg::OP_ADD) ? rbuy_q : hit_side_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= op_i;
      rid_q    <= order_id_i;
      rprice_q <= price_ticks_i;
      rqty_q   <= quantity_i;
      rbuy_q   <= is_buy_i;
    end
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (issue) begin
      rd_q    <= mem_q[ptr_q];
      slotv_q <= valid_q[ptr_q];
      idx_q   <= ptr_q;
    end
  end

  // address stepping, identifier match, lowest free slot, side flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q      <= '0;
      issued_q   <= 1'b0;
      pv_q       <= 1'b0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      have_bid_q <= 1'b0;
      have_ask_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      done_q <= cmd_i.reply;
      if (cmd_i.scan1_clr || cmd_i.scan2_clr) begin
        ptr_q    <= '0;
        issued_q <= 1'b0;
        pv_q     <= 1'b0;
      end else begin
        pv_q <= issue;
        if (issue) begin
          ptr_q    <= addr_last ? '0 : ptr_q + 1'b1;
          issued_q <= addr_last;
        end
      end
      if (cmd_i.scan1_clr) begin
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else if (cmd_i.scan1_en && pv_q) begin
        if (!hit_q && slotv_q && rd_q.id == rid_q && rid_q != '0) hit_q <= 1'b1;
        if (!free_q && !slotv_q) free_q <= 1'b1;
      end
      if (cmd_i.scan2_clr) begin
        have_bid_q <= 1'b0;
        have_ask_q <= 1'b0;
      end else if (cmd_i.scan2_en && pv_q && slotv_q) begin
        if (rd_q.side) have_bid_q <= 1'b1;
        else           have_ask_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan1_en && pv_q) begin
      if (!hit_q && slotv_q && rd_q.id == rid_q && rid_q != '0) begin
        hit_idx_q   <= idx_q;
        hit_price_q <= rd_q.price;
        hit_qty_q   <= rd_q.qty;
        hit_side_q  <= rd_q.side;
      end
      if (!free_q && !slotv_q) free_idx_q <= idx_q;
    end
    if (cmd_i.scan2_en && pv_q && slotv_q) begin
      if (rd_q.side) begin
        if (!have_bid_q || rd_q.price > bid_q) bid_q <= rd_q.price;
      end else begin
        if (!have_ask_q || rd_q.price < ask_q) ask_q <= rd_q.price;
      end
    end
  end

  // apply: update the valid bits and count; the status is decided in the block below
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
    end else if (cmd_i.apply) begin
      unique case (op_q)
        lobt_pkg::OP_ADD:
          if (params_ok && !hit_q && free_q) begin
            valid_q[free_idx_q] <= 1'b1;
            count_q <= count_q + 1'b1;
          end
        lobt_pkg::OP_DELETE:
          if (hit_q) begin
            valid_q[hit_idx_q] <= 1'b0;
            if (count_q != '0) count_q <= count_q - 1'b1;
          end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      fprice_q <= '0;
      fqty_q   <= '0;
      fbuy_q   <= 1'b0;
      status_q <= lobt_pkg::ST_OK;
      unique case (op_q)
        lobt_pkg::OP_ADD: begin
          if (!params_ok)  status_q <= lobt_pkg::ST_INVALID;
          else if (hit_q)  status_q <= lobt_pkg::ST_DUP;
          else if (!free_q) status_q <= lobt_pkg::ST_FULL;
        end
        lobt_pkg::OP_MODIFY: begin
          if (!params_ok) status_q <= lobt_pkg::ST_INVALID;
          else if (!hit_q) status_q <= lobt_pkg::ST_NOT_FOUND;
        end
        lobt_pkg::OP_DELETE: begin
          if (rid_q == '0) status_q <= lobt_pkg::ST_INVALID;
          else if (!hit_q) status_q <= lobt_pkg::ST_NOT_FOUND;
        end
        lobt_pkg::OP_LOOKUP: begin
          if (!hit_q) status_q <= lobt_pkg::ST_NOT_FOUND;
          else begin
            fprice_q <= hit_price_q;
            fqty_q   <= hit_qty_q;
            fbuy_q   <= hit_side_q;
          end
        end
        default: ;
      endcase
    end
  end

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign found_price_o    = fprice_q;
  assign found_quantity_o = fqty_q;
  assign found_is_buy_o   = fbuy_q;
  assign bid_valid_o      = have_bid_q;
  assign best_bid_o       = have_bid_q ? bid_q : '0;
  assign ask_valid_o      = have_ask_q;
  assign best_ask_o       = have_ask_q ? ask_q : '0;
  assign active_count_o   = 7'(count_q);

endmodule

// ===== hdl/lobt_checker.sv =====
// Checker: port-level properties of the order book table, bound to the top level.
module lobt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [2:0]  status_o,
  input logic        bid_valid_o,
  input logic [31:0] best_bid_o,
  input logic        ask_valid_o,
  input logic [31:0] best_ask_o,
  input logic [6:0]  active_count_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("accept did not raise busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("reply strobe longer than one cycle");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("reply while a request is in flight");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o <= lobt_pkg::ST_FULL)) else $error("status out of range");

  a_empty_book: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && active_count_o == 7'd0) |-> (!bid_valid_o && !ask_valid_o
      && best_bid_o == 32'd0 && best_ask_o == 32'd0)) else $error("prices on empty book");

endmodule

bind limit_order_book_table_top lobt_checker u_lobt_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o), .done_o(done_o),
  .status_o(status_o), .bid_valid_o(bid_valid_o), .best_bid_o(best_bid_o),
  .ask_valid_o(ask_valid_o), .best_ask_o(best_ask_o), .active_count_o(active_count_o)
);
